>>> hdl/srdc_pkg.sv
package srdc_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CNT_W  = 32;
  localparam int TIME_W = 53;
  localparam int THR_W  = 32;
  localparam int IV_W   = 20;
  localparam int OUT_W  = 32;

  // quotient width: accumulated count with fraction bits appended
  localparam int QW        = CNT_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(QW);
  localparam int MUL_CNT_W = $clog2(IV_W);

  localparam int IN_FIELDS_W = 2 * CNT_W + 2 * TIME_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_INTERVAL_US = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5000000);
  localparam logic [IV_W-1:0]  IV_RESET  = IV_W'(50000);

endpackage

>>> hdl/srdc_div.sv
module srdc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [srdc_pkg::QW-1:0]         dividend,
  input  logic [srdc_pkg::TIME_W-1:0]     divisor,
  output logic                            done,
  output logic [srdc_pkg::QW-1:0]         quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [srdc_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [srdc_pkg::QW-1:0]           num_r;
  logic [srdc_pkg::TIME_W-1:0]       rem_r;
  logic [srdc_pkg::TIME_W-1:0]       den_r;
  logic [srdc_pkg::TIME_W:0]         shifted;
  logic [srdc_pkg::TIME_W+1:0]       trial;

  // restoring division, one quotient bit a cycle; the numerator register
  // shifts out dividend bits at the top and takes quotient bits at the bottom
  assign shifted = {rem_r, num_r[srdc_pkg::QW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= dividend;
        den_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (!trial[srdc_pkg::TIME_W+1]) begin
          rem_r <= trial[srdc_pkg::TIME_W-1:0];
          num_r <= {num_r[srdc_pkg::QW-2:0], 1'b1};
        end else begin
          rem_r <= shifted[srdc_pkg::TIME_W-1:0];
          num_r <= {num_r[srdc_pkg::QW-2:0], 1'b0};
        end
        if (cnt_r == srdc_pkg::DIV_CNT_W'(srdc_pkg::QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

>>> hdl/sample_rate_drift_corrector_top.sv
// Sample-rate drift corrector.
// Input channel in_*: one transaction per report (remote/local sample counters
// and timestamps). Output channel out_*: one transaction carrying the running
// chunk correction for each report that closes a measurement window with
// non-zero time deltas; other reports produce nothing.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0: count
// threshold, 1: chunk interval in us); unknown indexes are ignored. Write only
// while the block is idle.
// A report that produces no result passes S_UPD and S_CHK before the input
// is free again; the first report after reset passes S_UPD only.
// A correcting report runs two bit-serial dividers side by side (S_DIV), a
// subtraction (S_SUB), a shift-add multiply by the interval (S_MUL) and
// S_FIN; the quotients carry 16 fraction bits, rounded off, so out_tdata is an
// integer, and the next report is taken only once the block is back in idle.
// The result sits in an output register, so the next report is accepted while
// it waits; if the receiver still stalls when the following result is ready,
// the block holds in its final step until out_tready.
// Reset (rst_n, synchronous) clears all history, the running correction and
// restores the register defaults; the next report only records marks.
module sample_rate_drift_corrector_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // remote_sample_count, remote_time_us, local_sample_count, local_time_us, pad
  input  logic [srdc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // chunk_correction
  output logic [srdc_pkg::OUT_W-1:0]          out_tdata,
  input  logic                                cfg_we,
  input  logic [srdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_CHK, S_DIV, S_SUB, S_MUL, S_FIN
  } state_t;

  localparam int CW = srdc_pkg::CNT_W;
  localparam int TW = srdc_pkg::TIME_W;
  localparam int QW = srdc_pkg::QW;

  state_t                           state_r;
  logic [srdc_pkg::THR_W-1:0]       thr_r;
  logic [srdc_pkg::IV_W-1:0]        ivcfg_r;

  logic [CW-1:0]                    last_rc_r, last_lc_r;
  logic [CW-1:0]                    drc_r, dlc_r;
  logic [TW-1:0]                    rt_r, lt_r;
  logic [TW-1:0]                    mark_rt_r, mark_lt_r;
  logic [CW-1:0]                    racc_r, lacc_r;
  logic [TW-1:0]                    dtr_r, dtl_r;
  logic [srdc_pkg::OUT_W-1:0]       run_r;
  logic                             neg_r;
  logic [QW-1:0]                    mag_r;
  logic [QW-1:0]                    prod_r;
  logic [srdc_pkg::IV_W-1:0]        iv_r;
  logic [srdc_pkg::MUL_CNT_W-1:0]   mcnt_r;
  logic                             out_tvalid_r;
  logic [srdc_pkg::OUT_W-1:0]       out_tdata_r;

  logic [CW-1:0]                    in_rc, in_lc;
  logic [TW-1:0]                    in_rt, in_lt;
  logic                             in_fire;
  logic                             div_start;
  logic                             div_r_done, div_l_done;
  logic [QW-1:0]                    qr, ql;
  logic [srdc_pkg::OUT_W-1:0]       corr, sum;

  assign in_rc = in_tdata[CW-1:0];
  assign in_rt = in_tdata[CW+TW-1:CW];
  assign in_lc = in_tdata[2*CW+TW-1:CW+TW];
  assign in_lt = in_tdata[2*CW+2*TW-1:2*CW+TW];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign div_start = (state_r == S_CHK) && (racc_r > thr_r) &&
                     (dtr_r != '0) && (dtl_r != '0);

  srdc_div u_div_remote (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({racc_r, {srdc_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (dtr_r),
    .done     (div_r_done),
    .quotient (qr)
  );

  srdc_div u_div_local (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({lacc_r, {srdc_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (dtl_r),
    .done     (div_l_done),
    .quotient (ql)
  );

  // round half away from zero: offset was preloaded, drop the fraction
  assign corr = prod_r[QW-1:srdc_pkg::FRAC_BITS];
  assign sum  = neg_r ? (run_r - corr) : (run_r + corr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= srdc_pkg::THR_RESET;
      ivcfg_r <= srdc_pkg::IV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srdc_pkg::CFG_COUNT_THRESHOLD:   thr_r   <= cfg_wdata[srdc_pkg::THR_W-1:0];
        srdc_pkg::CFG_CHUNK_INTERVAL_US: ivcfg_r <= cfg_wdata[srdc_pkg::IV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_rc_r    <= '0;
      last_lc_r    <= '0;
      mark_rt_r    <= '0;
      mark_lt_r    <= '0;
      racc_r       <= '0;
      lacc_r       <= '0;
      run_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // the final step reloads the output register itself
      if (out_tvalid_r && out_tready && (state_r != S_FIN)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            drc_r     <= in_rc - last_rc_r;
            dlc_r     <= in_lc - last_lc_r;
            last_rc_r <= in_rc;
            last_lc_r <= in_lc;
            rt_r      <= in_rt;
            lt_r      <= in_lt;
            state_r   <= S_UPD;
          end
        end
        S_UPD: begin
          if (mark_rt_r == '0) begin
            mark_rt_r <= rt_r;
            mark_lt_r <= lt_r;
            state_r   <= S_IDLE;
          end else begin
            racc_r  <= racc_r + drc_r;
            lacc_r  <= lacc_r + dlc_r;
            dtr_r   <= rt_r - mark_rt_r;
            dtl_r   <= lt_r - mark_lt_r;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (racc_r > thr_r) begin
            // close the window: move marks, clear accumulators
            mark_rt_r <= rt_r;
            mark_lt_r <= lt_r;
            racc_r    <= '0;
            lacc_r    <= '0;
            state_r   <= div_start ? S_DIV : S_IDLE;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_r_done && div_l_done) begin
            state_r <= S_SUB;
          end
        end
        S_SUB: begin
          if (qr >= ql) begin
            mag_r <= qr - ql;
            neg_r <= 1'b0;
          end else begin
            mag_r <= ql - qr;
            neg_r <= 1'b1;
          end
          prod_r  <= QW'(1) << (srdc_pkg::FRAC_BITS - 1);
          iv_r    <= ivcfg_r;
          mcnt_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // shift-add, one interval bit a cycle, LSB first
          if (iv_r[0]) begin
            prod_r <= prod_r + mag_r;
          end
          mag_r <= {mag_r[QW-2:0], 1'b0};
          iv_r  <= iv_r >> 1;
          if (mcnt_r == srdc_pkg::MUL_CNT_W'(srdc_pkg::IV_W - 1)) begin
            state_r <= S_FIN;
          end else begin
            mcnt_r <= mcnt_r + 1'b1;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            run_r        <= sum;
            out_tdata_r  <= sum;
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
